// ----- rtl/quaternion_integrate_normalize_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion integrate and normalize block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_INTEGRATE_NORMALIZE_ASSERT_SVH
`define QUATERNION_INTEGRATE_NORMALIZE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define QIN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define QIN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define QIN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define QIN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/qin_pkg.sv -----
// ----------------------------------------------------------------------------
// qin_pkg
// Types, widths and the cross-product term table of the quaternion
// integrate and normalize block.
// ----------------------------------------------------------------------------
package qin_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned DT_W   = 16;
  localparam int unsigned NLANES = 4;

  localparam logic [DT_W-1:0]          STEP_TIME_RESET = 16'd655;
  localparam logic signed [DATA_W-1:0] ONE_Q14         = 16'sd16384;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_LOAD      = 1'b1;

  // datapath widths
  localparam int unsigned MA_W       = 34;            // S fits 33 bits signed
  localparam int unsigned P_W        = 29;            // p with 20 fraction bits
  localparam int unsigned MB_W       = P_W;
  localparam int unsigned PROD_W     = MA_W + MB_W;
  localparam int unsigned ACC_W      = 56;            // holds S*dt and p^2
  localparam int unsigned N2_W       = 57;
  localparam int unsigned SQRT_STEPS = 29;
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;
  localparam int unsigned R_W        = SQRT_STEPS;
  localparam int unsigned SQ_REM_W   = R_W + 3;
  localparam int unsigned FRAC_SHIFT = 21;
  localparam int unsigned Q_SHIFT    = 6;
  localparam int unsigned NORM_SHIFT = 14;
  localparam int unsigned NUM_W      = P_W + NORM_SHIFT + 1;
  localparam int unsigned DIV_STEPS  = NUM_W - R_W;   // quotient never exceeds 2^14
  localparam int unsigned CNT_W      = $clog2(SQRT_STEPS);

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};

  // cross-product term steps and lanes
  localparam logic [1:0] TERM_A = 2'd0;
  localparam logic [1:0] TERM_B = 2'd1;
  localparam logic [1:0] TERM_C = 2'd2;

  localparam logic [1:0] LANE_W = 2'd0;
  localparam logic [1:0] LANE_X = 2'd1;
  localparam logic [1:0] LANE_Y = 2'd2;
  localparam logic [1:0] LANE_Z = 2'd3;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] omega_x;
    logic signed [DATA_W-1:0] omega_y;
    logic signed [DATA_W-1:0] omega_z;
    logic signed [DATA_W-1:0] load_w;
    logic signed [DATA_W-1:0] load_x;
    logic signed [DATA_W-1:0] load_y;
    logic signed [DATA_W-1:0] load_z;
  } qin_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_w;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     zero_norm;
  } qin_rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] om;
    logic signed [DATA_W-1:0] qv;
    logic                     neg;
  } qin_term_t;

  // Omega(w)*q split into three multiply steps per lane:
  //   S_w = -(wx qx + wy qy + wz qz)   S_x = wx qw + wy qz - wz qy
  //   S_y =  wy qw + wz qx - wx qz     S_z = wz qw + wx qy - wy qx
  function automatic qin_term_t qin_cross_term(
    input logic [1:0]               term,
    input logic [1:0]               lane,
    input qin_req_t                 rq,
    input logic signed [DATA_W-1:0] qw,
    input logic signed [DATA_W-1:0] qx,
    input logic signed [DATA_W-1:0] qy,
    input logic signed [DATA_W-1:0] qz
  );
    qin_term_t t;
    t = '0;
    case (term)
      TERM_A: begin
        case (lane)
          LANE_W:  t = '{om: rq.omega_x, qv: qx, neg: 1'b1};
          LANE_X:  t = '{om: rq.omega_x, qv: qw, neg: 1'b0};
          LANE_Y:  t = '{om: rq.omega_y, qv: qw, neg: 1'b0};
          default: t = '{om: rq.omega_z, qv: qw, neg: 1'b0};
        endcase
      end
      TERM_B: begin
        case (lane)
          LANE_W:  t = '{om: rq.omega_y, qv: qy, neg: 1'b1};
          LANE_X:  t = '{om: rq.omega_y, qv: qz, neg: 1'b0};
          LANE_Y:  t = '{om: rq.omega_z, qv: qx, neg: 1'b0};
          default: t = '{om: rq.omega_x, qv: qy, neg: 1'b0};
        endcase
      end
      TERM_C: begin
        case (lane)
          LANE_W:  t = '{om: rq.omega_z, qv: qz, neg: 1'b1};
          LANE_X:  t = '{om: rq.omega_z, qv: qy, neg: 1'b1};
          LANE_Y:  t = '{om: rq.omega_x, qv: qz, neg: 1'b1};
          default: t = '{om: rq.omega_y, qv: qx, neg: 1'b1};
        endcase
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/quaternion_integrate_normalize.sv -----
// ----------------------------------------------------------------------------
// quaternion_integrate_normalize
// Integrate request: three cross-product multiply/sum steps, S*dt, p update,
//   squared norm, square-root loop, divide loop and emit; a zero norm emits
//   the zero quaternion after the squared-norm step. A new request is taken
//   only once the sequencer is back in idle. Load request: emitted directly.
// Reset: quaternion (1,0,0,0), step_time 655, sequencer idle, output empty.
// ----------------------------------------------------------------------------
`include "quaternion_integrate_normalize_assert.svh"

module quaternion_integrate_normalize (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qin_pkg::DT_W-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  qin_pkg::qin_req_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output qin_pkg::qin_rsp_t              out_data_o
);
  import qin_pkg::*;

  typedef enum logic [3:0] {
    U_IDLE, U_LOAD, U_C0, U_C1, U_C2, U_DT, U_P, U_SQ,
    U_N2, U_SQRT, U_DINIT, U_DIV, U_FIN, U_ZERO
  } upc_e;

  typedef enum logic [1:0] {MUL_CROSS, MUL_SDT, MUL_PSQ} mul_sel_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_e;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_LOAD, EMIT_NORM, EMIT_ZERO} emit_e;
  typedef enum logic [1:0] {JMP_GOTO, JMP_DISPATCH, JMP_LOOP, JMP_ZERO} jump_e;

  typedef struct packed {
    mul_sel_e   mul;
    logic [1:0] term;
    acc_op_e    acc;
    logic       p_ld;
    logic       sq_init;
    logic       sq_step;
    logic       dv_init;
    logic       dv_step;
    emit_e      emit;
    jump_e      jump;
    upc_e       target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_e a);
    ucode_t w;
    w = '0;
    case (a)
      U_IDLE:  w.jump = JMP_DISPATCH;
      U_LOAD:  begin w.emit = EMIT_LOAD; w.target = U_IDLE; end
      U_C0:    begin w.term = TERM_A; w.acc = ACC_LOAD; w.target = U_C1; end
      U_C1:    begin w.term = TERM_B; w.acc = ACC_ADD;  w.target = U_C2; end
      U_C2:    begin w.term = TERM_C; w.acc = ACC_ADD;  w.target = U_DT; end
      U_DT:    begin w.mul = MUL_SDT; w.acc = ACC_LOAD; w.target = U_P; end
      U_P:     begin w.p_ld = 1'b1; w.target = U_SQ; end
      U_SQ:    begin
        w.mul = MUL_PSQ; w.acc = ACC_LOAD; w.jump = JMP_ZERO; w.target = U_N2;
      end
      U_N2:    begin w.sq_init = 1'b1; w.target = U_SQRT; end
      U_SQRT:  begin w.sq_step = 1'b1; w.jump = JMP_LOOP; w.target = U_DINIT; end
      U_DINIT: begin w.dv_init = 1'b1; w.target = U_DIV; end
      U_DIV:   begin w.dv_step = 1'b1; w.jump = JMP_LOOP; w.target = U_FIN; end
      U_FIN:   begin w.emit = EMIT_NORM; w.target = U_IDLE; end
      U_ZERO:  begin w.emit = EMIT_ZERO; w.target = U_IDLE; end
      default: w.target = U_IDLE;
    endcase
    return w;
  endfunction

  // sequencer and architectural state
  upc_e                     pc_q, pc_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DT_W-1:0]          step_time_q;
  logic signed [DATA_W-1:0] q_q [NLANES];
  qin_rsp_t                 out_q, rsp_d;
  logic                     out_valid_q;

  // datapath
  qin_req_t                 in_q;
  logic signed [ACC_W-1:0]  acc_q [NLANES];
  logic signed [ACC_W-1:0]  acc_d [NLANES];
  logic signed [P_W-1:0]    p_q   [NLANES];
  logic signed [P_W-1:0]    p_d   [NLANES];
  logic [RAD_W-1:0]         rad_q;
  logic [SQ_REM_W-1:0]      sqrem_q, sqrem_d;
  logic [R_W-1:0]           root_q, root_d;
  logic [R_W-1:0]           drem_q [NLANES];
  logic [R_W-1:0]           drem_d [NLANES];
  logic [DIV_STEPS-1:0]     dquo_q [NLANES];
  logic                     dquo_bit [NLANES];
  logic                     dneg_q [NLANES];
  logic [NUM_W-1:0]         num    [NLANES];
  logic signed [DATA_W-1:0] norm_res [NLANES];

  ucode_t                   uc;
  logic                     out_free, emit_fire, in_fire, p_zero, cnt_zero;
  logic                     rsp_zero_ok;
  logic [N2_W-1:0]          n2;

  qin_term_t                term   [NLANES];
  logic signed [MA_W-1:0]   mul_a  [NLANES];
  logic signed [MB_W-1:0]   mul_b  [NLANES];
  logic signed [PROD_W-1:0] prod   [NLANES];
  logic signed [ACC_W-1:0]  prod_s [NLANES];

  assign uc          = ucode_rom(pc_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_fire   = (uc.emit != EMIT_NONE) && out_free;
  assign in_stall_o  = (pc_q != U_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cnt_zero    = (cnt_q == '0);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a zero-norm result carries the zero quaternion
  assign rsp_zero_ok = !out_q.zero_norm ||
                       ((out_q.out_w == '0) && (out_q.out_x == '0) &&
                        (out_q.out_y == '0) && (out_q.out_z == '0));

  // lane datapath: one multiplier per quaternion component
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      logic signed [ACC_W-1:0]  rnd;
      logic [P_W-1:0]           mag;
      logic [R_W:0]             rs;
      logic [DATA_W-1:0]        quo;
      term[i] = qin_cross_term(uc.term, 2'(i), in_q, q_q[0], q_q[1], q_q[2], q_q[3]);
      case (uc.mul)
        MUL_SDT: begin
          mul_a[i] = acc_q[i][MA_W-1:0];
          mul_b[i] = {{(MB_W-DT_W){1'b0}}, step_time_q};
        end
        MUL_PSQ: begin
          mul_a[i] = {{(MA_W-P_W){p_q[i][P_W-1]}}, p_q[i]};
          mul_b[i] = p_q[i];
        end
        default: begin
          mul_a[i] = {{(MA_W-DATA_W){term[i].om[DATA_W-1]}}, term[i].om};
          mul_b[i] = {{(MB_W-DATA_W){term[i].qv[DATA_W-1]}}, term[i].qv};
        end
      endcase
      prod[i] = mul_a[i] * mul_b[i];
      prod_s[i] = (uc.mul == MUL_CROSS && term[i].neg) ? -prod[i][ACC_W-1:0]
                                                         : prod[i][ACC_W-1:0];
      case (uc.acc)
        ACC_LOAD: acc_d[i] = prod_s[i];
        ACC_ADD:  acc_d[i] = acc_q[i] + prod_s[i];
        default:  acc_d[i] = acc_q[i];
      endcase

      // p = q*2^6 + floor((S*dt + 2^20) / 2^21)
      rnd    = acc_q[i] + ROUND_HALF;
      p_d[i] = rnd[FRAC_SHIFT +: P_W]
             + {{(P_W-DATA_W-Q_SHIFT){q_q[i][DATA_W-1]}}, q_q[i], {Q_SHIFT{1'b0}}};

      // divide |p|*2^14 + r/2 by r, one quotient bit per step
      mag    = p_q[i][P_W-1] ? -p_q[i] : p_q[i];
      num[i] = {1'b0, mag, {NORM_SHIFT{1'b0}}} + NUM_W'(root_q >> 1);
      rs          = {drem_q[i], dquo_q[i][DIV_STEPS-1]};
      dquo_bit[i] = (rs >= {1'b0, root_q});
      drem_d[i]   = dquo_bit[i] ? R_W'(rs - {1'b0, root_q}) : rs[R_W-1:0];

      quo         = {{(DATA_W-DIV_STEPS){1'b0}}, dquo_q[i]};
      norm_res[i] = dneg_q[i] ? -quo : quo;
    end
  end

  // squared norm and one root bit per step
  always_comb begin
    logic [SQ_REM_W-1:0] rs;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;
    n2     = '0;
    p_zero = 1'b1;
    for (int i = 0; i < NLANES; i++) begin
      n2 = n2 + {{(N2_W-ACC_W+1){1'b0}}, acc_q[i][ACC_W-2:0]};
      p_zero = p_zero && (p_q[i] == '0);
    end
    rs      = {sqrem_q[SQ_REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (rs >= trial);
    sqrem_d = ge ? rs - trial : rs;
    root_d  = {root_q[R_W-2:0], ge};
  end

  // next step, counter and result
  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    rsp_d = out_q;
    case (uc.jump)
      JMP_DISPATCH: begin
        if (in_fire) begin
          pc_d = (in_data_i.opcode == OP_LOAD) ? U_LOAD : U_C0;
        end
      end
      JMP_LOOP: begin
        if (cnt_zero) begin
          pc_d = uc.target;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      JMP_ZERO: pc_d = p_zero ? U_ZERO : uc.target;
      default: begin
        // an emit step waits for the output register
        if (uc.emit == EMIT_NONE || out_free) begin
          pc_d = uc.target;
        end
      end
    endcase
    if (uc.sq_init) begin
      cnt_d = CNT_W'(SQRT_STEPS - 1);
    end else if (uc.dv_init) begin
      cnt_d = CNT_W'(DIV_STEPS - 1);
    end
    case (uc.emit)
      EMIT_LOAD: rsp_d = '{out_w: in_q.load_w, out_x: in_q.load_x, out_y: in_q.load_y,
                           out_z: in_q.load_z, zero_norm: 1'b0};
      EMIT_NORM: rsp_d = '{out_w: norm_res[0], out_x: norm_res[1], out_y: norm_res[2],
                           out_z: norm_res[3], zero_norm: 1'b0};
      EMIT_ZERO: rsp_d = '{out_w: '0, out_x: '0, out_y: '0, out_z: '0, zero_norm: 1'b1};
      default:   rsp_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= U_IDLE;
      cnt_q       <= '0;
      step_time_q <= STEP_TIME_RESET;
      q_q[0]      <= ONE_Q14;
      for (int i = 1; i < NLANES; i++) begin
        q_q[i] <= '0;
      end
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        step_time_q <= cfg_wdata_i;
      end
      if (emit_fire) begin
        out_q       <= rsp_d;
        out_valid_q <= 1'b1;
        q_q[0]      <= rsp_d.out_w;
        q_q[1]      <= rsp_d.out_x;
        q_q[2]      <= rsp_d.out_y;
        q_q[3]      <= rsp_d.out_z;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    for (int i = 0; i < NLANES; i++) begin
      acc_q[i] <= acc_d[i];
      if (uc.p_ld) begin
        p_q[i] <= p_d[i];
      end
      if (uc.dv_init) begin
        drem_q[i] <= num[i][NUM_W-1:DIV_STEPS];
        dquo_q[i] <= num[i][DIV_STEPS-1:0];
        dneg_q[i] <= p_q[i][P_W-1];
      end else if (uc.dv_step) begin
        drem_q[i] <= drem_d[i];
        dquo_q[i] <= {dquo_q[i][DIV_STEPS-2:0], dquo_bit[i]};
      end
    end
    if (uc.sq_init) begin
      rad_q   <= {1'b0, n2};
      sqrem_q <= '0;
      root_q  <= '0;
    end else if (uc.sq_step) begin
      rad_q   <= rad_q << 2;
      sqrem_q <= sqrem_d;
      root_q  <= root_d;
    end
  end

  `QIN_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `QIN_ASSERT_IMPLY(a_zero_flag_zero_quat, clk_i, rst_ni, out_valid_o, rsp_zero_ok)
  `QIN_ASSERT_IMPLY(a_div_rem_below_root, clk_i, rst_ni, pc_q == U_DIV, drem_q[0] < root_q)
  `QIN_ASSERT_IMPLY(a_result_returns_idle, clk_i, rst_ni, $rose(out_valid_o), pc_q == U_IDLE)

endmodule
